[rtl/core/hrir_pkg.sv]
// Package for the heart rate incline regulator: word types, codes, constants, step helpers.
`default_nettype none
package hrir_pkg;

   // request opcodes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_UP    = 3'd1;
   localparam logic [2:0] OP_DOWN  = 3'd2;
   localparam logic [2:0] OP_SET   = 3'd3;
   localparam logic [2:0] OP_LOAD  = 3'd4;

   // tone codes
   localparam logic [1:0] TONE_NONE   = 2'd0;
   localparam logic [1:0] TONE_ACCEPT = 2'd1;
   localparam logic [1:0] TONE_REJECT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_TARGET  = 2'd0;
   localparam logic [1:0] CSR_INC_MAX = 2'd1;
   localparam logic [1:0] CSR_INC_DEF = 2'd2;
   localparam logic [1:0] CSR_SPD_MIN = 2'd3;

   // configuration reset values
   localparam logic [7:0] TARGET_RESET  = 8'd120;
   localparam logic [7:0] INC_MAX_RESET = 8'd15;
   localparam logic [7:0] INC_DEF_RESET = 8'd0;
   localparam logic [7:0] SPD_MIN_RESET = 8'd8;

   // timing and regulation constants
   localparam logic [3:0] PULSE_LAST      = 4'd15;
   localparam logic [4:0] NO_PULSE_LIMIT  = 5'd29;
   localparam logic [4:0] NO_PULSE_RELOAD = 5'd25;
   localparam logic [7:0] GAP_BIG         = 8'd25;
   localparam logic [7:0] GAP_SMALL       = 8'd5;
   localparam logic [7:0] SPEED_DROP      = 8'd4;
   localparam logic [7:0] STEP_ONE        = 8'd1;
   localparam logic [7:0] STEP_TWO        = 8'd2;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] wireless_pulse;
      logic [7:0] wired_pulse;
      logic       incline_fault;
      logic       quiet_keys;
      logic [7:0] value;
   } req_word_type;

   typedef struct packed {
      logic [7:0] incline_level;
      logic [7:0] speed_value;
      logic [1:0] tone;
      logic       pulse_present;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] target_heart_rate;
      logic [7:0] incline_max;
      logic [7:0] incline_default;
      logic [7:0] speed_min;
   } cfg_type;

   function automatic logic [7:0] step_up(input logic [7:0] incl, input logic [7:0] amount,
                                          input logic [7:0] lim);
      step_up = (incl < lim) ? incl + amount : lim;
   endfunction

   // a step that would reach zero or start at or below the floor lands on the floor
   function automatic logic [7:0] step_down(input logic [7:0] incl, input logic [7:0] amount,
                                            input logic [7:0] floor_lvl);
      if (incl <= amount)
         step_down = floor_lvl;
      else if (incl > floor_lvl)
         step_down = incl - amount;
      else
         step_down = floor_lvl;
   endfunction

endpackage
`default_nettype wire

[rtl/core/heart_rate_incline_regulator.sv]
// Top level of the heart rate incline regulator: stream ports, input and result registers.
//
//   channel  dir  ports                         word
//   req      in   req_tvalid/tready/tdata/tuser one tick or key event
//   rsp      out  rsp_tvalid/tready/tdata       one result per request word
//   csr      in   csr_valid/ready/index/data    write of one configuration register
//
// One word per cycle while rsp_tready is high; path: input register, then result register.
// All regulation logic sits between those two registers and updates state as a word moves on.
// Reset is synchronous: counters, incline and speed clear, configuration takes its defaults.
// With rsp_tready low the result holds; the input register takes one more word if empty.
// csr is always ready and must only be written while no request is in flight.
`default_nettype none
module heart_rate_incline_regulator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // wireless_pulse[7:0] wired_pulse[15:8] incline_fault[16] quiet_keys[17] value[25:18]
   input  wire logic [hrir_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[2:0]
   input  wire logic [2:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // incline_level[7:0] speed_value[15:8] tone[17:16] pulse_present[18]
   output logic [hrir_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [7:0]                         csr_data
);
   import hrir_pkg::*;

   cfg_type      cfg;
   req_word_type req_word;
   req_word_type req_word_ff;
   rsp_word_type rsp_word;
   rsp_word_type rsp_word_ff;
   logic         req_valid_ff, req_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         fire;

   assign req_word.opcode         = req_tuser;
   assign req_word.wireless_pulse = req_tdata[7:0];
   assign req_word.wired_pulse    = req_tdata[15:8];
   assign req_word.incline_fault  = req_tdata[16];
   assign req_word.quiet_keys     = req_tdata[17];
   assign req_word.value          = req_tdata[25:18];

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign fire       = req_valid_ff && advance;

   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready)
         req_word_ff <= req_word;
      if (fire)
         rsp_word_ff <= rsp_word;
   end

   hrir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hrir_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_word (req_word_ff),
      .cfg      (cfg),
      .rsp_word (rsp_word)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_word_ff.pulse_present, rsp_word_ff.tone,
                        rsp_word_ff.speed_value, rsp_word_ff.incline_level};

endmodule
`default_nettype wire

[rtl/core/hrir_csr.sv]
// Configuration register bank for the regulator.
`default_nettype none
module hrir_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [7:0]       csr_data,
   output hrir_pkg::cfg_type     cfg
);
   import hrir_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET:  cfg_in.target_heart_rate = csr_data;
            CSR_INC_MAX: cfg_in.incline_max       = csr_data;
            CSR_INC_DEF: cfg_in.incline_default   = csr_data;
            CSR_SPD_MIN: cfg_in.speed_min         = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_heart_rate <= TARGET_RESET;
         cfg_ff.incline_max       <= INC_MAX_RESET;
         cfg_ff.incline_default   <= INC_DEF_RESET;
         cfg_ff.speed_min         <= SPD_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/hrir_core.sv]
// Regulator state and the combinational next-state and result logic.
`default_nettype none
module hrir_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire hrir_pkg::req_word_type req_word,
   input  wire hrir_pkg::cfg_type     cfg,
   output hrir_pkg::rsp_word_type     rsp_word
);
   import hrir_pkg::*;

   logic [3:0] pulse_seconds_ff, pulse_seconds_in;
   logic [4:0] no_pulse_seconds_ff, no_pulse_seconds_in;
   logic       phase_toggle_ff, phase_toggle_in;
   logic [7:0] incline_ff, incline_in;
   logic [7:0] speed_ff, speed_in;

   logic       pulse;
   logic [7:0] heart;
   logic [1:0] tone;

   assign pulse = (req_word.wireless_pulse != 8'd0) || (req_word.wired_pulse != 8'd0);
   assign heart = (req_word.wireless_pulse != 8'd0) ? req_word.wireless_pulse
                                                     : req_word.wired_pulse;

   always_comb begin
      pulse_seconds_in    = pulse_seconds_ff;
      no_pulse_seconds_in = no_pulse_seconds_ff;
      phase_toggle_in     = phase_toggle_ff;
      incline_in          = incline_ff;
      speed_in            = speed_ff;
      tone                = TONE_NONE;

      if ((req_word.opcode inside {OP_UP, OP_DOWN, OP_SET}) && !req_word.quiet_keys)
         tone = TONE_REJECT;

      case (req_word.opcode)
         OP_TICK: begin
            if (pulse) begin
               pulse_seconds_in    = pulse_seconds_ff + 4'd1;
               no_pulse_seconds_in = 5'd0;
               if (pulse_seconds_in == PULSE_LAST) begin
                  pulse_seconds_in = 4'd0;
                  phase_toggle_in  = !phase_toggle_ff;
                  // incline phase: move toward the target unless faulted
                  if (!phase_toggle_ff && !req_word.incline_fault) begin
                     if (heart > cfg.target_heart_rate) begin
                        if (heart - cfg.target_heart_rate >= GAP_BIG)
                           incline_in = step_down(incline_ff, STEP_TWO, cfg.incline_default);
                        else if (heart - cfg.target_heart_rate >= GAP_SMALL)
                           incline_in = step_down(incline_ff, STEP_ONE, cfg.incline_default);
                     end else if (cfg.target_heart_rate - heart >= GAP_SMALL) begin
                        incline_in = step_up(incline_ff, STEP_ONE, cfg.incline_max);
                     end
                  end
               end
            end else begin
               pulse_seconds_in    = 4'd0;
               no_pulse_seconds_in = no_pulse_seconds_ff + 5'd1;
               if (no_pulse_seconds_in > NO_PULSE_LIMIT) begin
                  no_pulse_seconds_in = NO_PULSE_RELOAD;
                  incline_in = step_down(incline_ff, STEP_ONE, cfg.incline_default);
                  if (speed_ff > SPEED_DROP)
                     speed_in = speed_ff - SPEED_DROP;
                  if (speed_in <= cfg.speed_min)
                     speed_in = cfg.speed_min;
               end
            end
         end
         OP_UP: begin
            if (!req_word.incline_fault) begin
               if (incline_ff < cfg.incline_max) begin
                  incline_in = incline_ff + 8'd1;
                  if (!req_word.quiet_keys)
                     tone = TONE_ACCEPT;
               end else begin
                  incline_in = cfg.incline_max;
               end
            end
         end
         OP_DOWN: begin
            if (!req_word.incline_fault) begin
               if (incline_ff > cfg.incline_default) begin
                  incline_in = incline_ff - 8'd1;
                  if (!req_word.quiet_keys)
                     tone = TONE_ACCEPT;
               end else begin
                  incline_in = cfg.incline_default;
               end
            end
         end
         OP_SET: begin
            if (!req_word.incline_fault) begin
               incline_in = req_word.value;
               tone       = TONE_ACCEPT;
            end
         end
         OP_LOAD: speed_in = req_word.value;
         default: tone = TONE_NONE;
      endcase
   end

   assign rsp_word.incline_level = incline_in;
   assign rsp_word.speed_value   = speed_in;
   assign rsp_word.tone          = tone;
   assign rsp_word.pulse_present = pulse;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_seconds_ff    <= 4'd0;
         no_pulse_seconds_ff <= 5'd0;
         phase_toggle_ff     <= 1'b0;
         incline_ff          <= 8'd0;
         speed_ff            <= 8'd0;
      end else if (fire) begin
         pulse_seconds_ff    <= pulse_seconds_in;
         no_pulse_seconds_ff <= no_pulse_seconds_in;
         phase_toggle_ff     <= phase_toggle_in;
         incline_ff          <= incline_in;
         speed_ff            <= speed_in;
      end
   end

   // phase counter wraps before it can show its last count
   a_pulse_wrap: assert property (@(posedge clock) disable iff (reset)
      pulse_seconds_ff != PULSE_LAST)
      else $error("pulse second counter reached its wrap value");

   // no-pulse counter reloads once past its limit
   a_no_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      no_pulse_seconds_ff <= NO_PULSE_LIMIT)
      else $error("no-pulse counter past its limit");

   a_speed_load: assert property (@(posedge clock) disable iff (reset)
      fire && (req_word.opcode == OP_LOAD) |=> speed_ff == $past(req_word.value))
      else $error("speed load not taken");

   a_tone_code: assert property (@(posedge clock) disable iff (reset)
      (req_word.opcode == OP_TICK) |-> tone == TONE_NONE)
      else $error("tick produced a tone");

endmodule
`default_nettype wire

[verif/hrir_checker.sv]
// Checker for the heart rate incline regulator: tracks config, predicts each readout, compares.
module hrir_checker
   import hrir_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   // wireless_pulse[7:0] wired_pulse[15:8] incline_fault[16] quiet_keys[17] value[25:18]
   input  wire logic [REQ_TDATA_W-1:0]   req_tdata,
   // opcode[2:0]
   input  wire logic [2:0]               req_tuser,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // incline_level[7:0] speed_value[15:8] tone[17:16] pulse_present[18]
   input  wire logic [RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [7:0]               csr_data,
   output int                            mismatch_count,
   output int                            readouts_due
);

   cfg_type      cfg;
   logic [3:0]   pulse_secs;
   logic [4:0]   dropout_secs;
   logic         incline_phase;
   logic [7:0]   incline_lvl;
   logic [7:0]   speed_lvl;
   rsp_word_type predicted_readouts[$];

   req_word_type seen_req;
   rsp_word_type seen_rsp;
   rsp_word_type want_rsp;
   int           readout_num;

   initial begin
      mismatch_count = 0;
      readouts_due   = 0;
      readout_num    = 0;
   end

   function automatic void raise_incline(input logic [7:0] amount);
      if (incline_lvl < cfg.incline_max)
         incline_lvl = incline_lvl + amount;
      else
         incline_lvl = cfg.incline_max;
   endfunction

   // lands on the floor when the step would reach zero or incline sits at or below the floor
   function automatic void lower_incline(input logic [7:0] amount);
      if (incline_lvl <= amount)
         incline_lvl = cfg.incline_default;
      else if (incline_lvl > cfg.incline_default)
         incline_lvl = incline_lvl - amount;
      else
         incline_lvl = cfg.incline_default;
   endfunction

   function automatic rsp_word_type regulate_word(input req_word_type w);
      rsp_word_type r;
      logic         has_pulse;
      logic [7:0]   heart;
      logic [7:0]   gap;
      has_pulse = (w.wireless_pulse != 8'd0) || (w.wired_pulse != 8'd0);
      r.tone = TONE_NONE;
      if (w.opcode >= OP_UP && w.opcode <= OP_SET && !w.quiet_keys)
         r.tone = TONE_REJECT;
      case (w.opcode)
         OP_TICK: begin
            if (has_pulse) begin
               pulse_secs   = pulse_secs + 4'd1;
               dropout_secs = 5'd0;
               if (pulse_secs == PULSE_LAST) begin
                  heart      = (w.wireless_pulse == 8'd0) ? w.wired_pulse : w.wireless_pulse;
                  pulse_secs = 4'd0;
                  if (incline_phase) begin
                     incline_phase = 1'b0;
                  end else begin
                     incline_phase = 1'b1;
                     if (!w.incline_fault) begin
                        if (heart > cfg.target_heart_rate) begin
                           gap = heart - cfg.target_heart_rate;
                           if (gap >= GAP_BIG)
                              lower_incline(STEP_TWO);
                           else if (gap >= GAP_SMALL)
                              lower_incline(STEP_ONE);
                        end else begin
                           gap = cfg.target_heart_rate - heart;
                           if (gap >= GAP_SMALL)
                              raise_incline(STEP_ONE);
                        end
                     end
                  end
               end
            end else begin
               pulse_secs   = 4'd0;
               dropout_secs = dropout_secs + 5'd1;
               // no-pulse lowering does not look at the fault flag
               if (dropout_secs > NO_PULSE_LIMIT) begin
                  dropout_secs = NO_PULSE_RELOAD;
                  lower_incline(STEP_ONE);
                  if (speed_lvl > SPEED_DROP)
                     speed_lvl = speed_lvl - SPEED_DROP;
                  if (speed_lvl <= cfg.speed_min)
                     speed_lvl = cfg.speed_min;
               end
            end
         end
         OP_UP: begin
            if (!w.incline_fault) begin
               if (incline_lvl < cfg.incline_max) begin
                  incline_lvl = incline_lvl + 8'd1;
                  if (!w.quiet_keys)
                     r.tone = TONE_ACCEPT;
               end else begin
                  incline_lvl = cfg.incline_max;
               end
            end
         end
         OP_DOWN: begin
            if (!w.incline_fault) begin
               if (incline_lvl > cfg.incline_default) begin
                  incline_lvl = incline_lvl - 8'd1;
                  if (!w.quiet_keys)
                     r.tone = TONE_ACCEPT;
               end else begin
                  incline_lvl = cfg.incline_default;
               end
            end
         end
         OP_SET: begin
            if (!w.incline_fault) begin
               incline_lvl = w.value;
               r.tone      = TONE_ACCEPT;
            end
         end
         OP_LOAD: speed_lvl = w.value;
         default: ;
      endcase
      r.incline_level = incline_lvl;
      r.speed_value   = speed_lvl;
      r.pulse_present = has_pulse;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.target_heart_rate = TARGET_RESET;
         cfg.incline_max       = INC_MAX_RESET;
         cfg.incline_default   = INC_DEF_RESET;
         cfg.speed_min         = SPD_MIN_RESET;
         pulse_secs            = 4'd0;
         dropout_secs          = 5'd0;
         incline_phase         = 1'b0;
         incline_lvl           = 8'd0;
         speed_lvl             = 8'd0;
         predicted_readouts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET:  cfg.target_heart_rate = csr_data;
               CSR_INC_MAX: cfg.incline_max       = csr_data;
               CSR_INC_DEF: cfg.incline_default   = csr_data;
               CSR_SPD_MIN: cfg.speed_min         = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.incline_level = rsp_tdata[7:0];
            seen_rsp.speed_value   = rsp_tdata[15:8];
            seen_rsp.tone          = rsp_tdata[17:16];
            seen_rsp.pulse_present = rsp_tdata[18];
            if (predicted_readouts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("readout %0d arrived with none outstanding: incline %0d speed %0d",
                           readout_num, seen_rsp.incline_level, seen_rsp.speed_value);
            end else begin
               want_rsp = predicted_readouts.pop_front();
               if (seen_rsp.incline_level !== want_rsp.incline_level ||
                   seen_rsp.speed_value   !== want_rsp.speed_value   ||
                   seen_rsp.tone          !== want_rsp.tone          ||
                   seen_rsp.pulse_present !== want_rsp.pulse_present) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("readout %0d: expected incline %0d speed %0d tone %0d pulse %0d, got incline %0d speed %0d tone %0d pulse %0d",
                              readout_num, want_rsp.incline_level, want_rsp.speed_value,
                              want_rsp.tone, want_rsp.pulse_present,
                              seen_rsp.incline_level, seen_rsp.speed_value,
                              seen_rsp.tone, seen_rsp.pulse_present);
               end
            end
            readout_num++;
         end
         if (req_tvalid && req_tready) begin
            seen_req.opcode         = req_tuser;
            seen_req.wireless_pulse = req_tdata[7:0];
            seen_req.wired_pulse    = req_tdata[15:8];
            seen_req.incline_fault  = req_tdata[16];
            seen_req.quiet_keys     = req_tdata[17];
            seen_req.value          = req_tdata[25:18];
            predicted_readouts.push_back(regulate_word(seen_req));
         end
      end
      readouts_due = predicted_readouts.size();
   end

endmodule

[verif/tb_heart_rate_incline_regulator.sv]
// Testbench top for the heart rate incline regulator: clock, reset, stimulus and verdict.
module tb_heart_rate_incline_regulator;
   import hrir_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_EVERY_THIRD} ready_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [2:0]             req_tuser  = 3'd0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index  = 2'd0;
   logic [7:0]             csr_data   = 8'd0;

   int                     mismatch_count;
   int                     readouts_due;
   int                     cycle_count = 0;
   int                     burst_left  = 0;

   ready_mode_type         ready_mode = READY_ALWAYS;
   int                     mode_left  = 0;
   int                     ready_tick = 0;

   // config as last written, used only to aim the stimulus
   logic [7:0]             set_target  = TARGET_RESET;
   logic [7:0]             set_max     = INC_MAX_RESET;
   logic [7:0]             set_default = INC_DEF_RESET;

   heart_rate_incline_regulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   hrir_checker regulator_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .readouts_due   (readouts_due)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("heart_rate_incline_regulator test failed");
         $finish;
      end
   end

   // receiver backpressure: switches between a few patterns every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(32, 200);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
         READY_ALWAYS:  rsp_tready <= 1'b1;
         READY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
         default:       rsp_tready <= (ready_tick % 3 == 0);
      endcase
   end

   function automatic req_word_type make_word(input logic [2:0] op, input logic [7:0] wl,
                                              input logic [7:0] wd, input logic fault,
                                              input logic quiet, input logic [7:0] v);
      req_word_type w;
      w.opcode         = op;
      w.wireless_pulse = wl;
      w.wired_pulse    = wd;
      w.incline_fault  = fault;
      w.quiet_keys     = quiet;
      w.value          = v;
      return w;
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      logic [REQ_TDATA_W-1:0] flat;
      int                     gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(60, 150);
         end else begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      flat       = '0;
      flat[25:0] = {w.value, w.quiet_keys, w.incline_fault, w.wired_pulse, w.wireless_pulse};
      req_tvalid <= 1'b1;
      req_tdata  <= flat;
      req_tuser  <= w.opcode;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (readouts_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] t, input logic [7:0] m,
                                input logic [7:0] d, input logic [7:0] s);
      wait_drained();
      write_reg(CSR_TARGET, t);
      write_reg(CSR_INC_MAX, m);
      write_reg(CSR_INC_DEF, d);
      write_reg(CSR_SPD_MIN, s);
      csr_valid   <= 1'b0;
      set_target  = t;
      set_max     = m;
      set_default = d;
   endtask

   task automatic random_phase(input int quota);
      int         sent;
      int         pick;
      int         len;
      int         h;
      logic [7:0] heart;
      logic [7:0] wl;
      logic [7:0] wd;
      logic [7:0] v;
      logic [2:0] op;
      logic       fault_run;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            // steady pulse near the target, long enough to reach regulation
            len = $urandom_range(15, 48);
            h   = int'(set_target) + int'($urandom_range(0, 80)) - 35;
            if (h < 1)
               h = 1;
            if (h > 255)
               h = 255;
            heart     = 8'(h);
            fault_run = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  op = 3'($urandom_range(OP_UP, OP_SET));
                  send_word(make_word(op, heart, 8'($urandom_range(0, 255)),
                                      ($urandom_range(0, 5) == 0), 1'($urandom_range(0, 1)),
                                      8'($urandom_range(set_default, set_max))));
               end else begin
                  case ($urandom_range(0, 3))
                     0: begin wl = 8'd0; wd = heart; end
                     1: begin wl = heart; wd = 8'($urandom_range(1, 255)); end
                     2: begin wl = heart; wd = 8'd0; end
                     default: begin wl = heart; wd = heart; end
                  endcase
                  // occasional dropout breaks the count
                  if ($urandom_range(0, 39) == 0) begin
                     wl = 8'd0;
                     wd = 8'd0;
                  end
                  send_word(make_word(OP_TICK, wl, wd,
                                      fault_run | ($urandom_range(0, 15) == 0),
                                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
               end
            end
            sent += len;
         end else if (pick < 12) begin
            // lost pulse: load a speed first so the slow-down shows
            if ($urandom_range(0, 3) == 0)
               v = 8'($urandom_range(0, 12));
            else
               v = 8'($urandom_range(0, 255));
            send_word(make_word(OP_LOAD, 8'd0, 8'd0, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), v));
            len = $urandom_range(30, 60);
            for (int i = 0; i < len; i++)
               send_word(make_word(OP_TICK, 8'd0, 8'd0, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
            sent += len + 1;
         end else if (pick < 17) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               op = 3'($urandom_range(OP_UP, OP_SET));
               if ($urandom_range(0, 3) == 0)
                  v = 8'($urandom_range(0, 255));
               else
                  v = 8'($urandom_range(set_default, set_max));
               send_word(make_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   ($urandom_range(0, 5) == 0), 1'($urandom_range(0, 1)), v));
            end
            sent += len;
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_word(make_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
            sent += len;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under the reset configuration
      send_word(make_word(OP_LOAD, 8'd0, 8'd0, 1'b0, 1'b0, 8'd255));
      send_word(make_word(OP_LOAD, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_UP, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_UP, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0));
      send_word(make_word(OP_SET, 8'd0, 8'd0, 1'b0, 1'b0, INC_MAX_RESET));
      send_word(make_word(OP_UP, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_UP, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0));
      // quick set is not clamped, next up key pulls it back to the max
      send_word(make_word(OP_SET, 8'd0, 8'd0, 1'b0, 1'b1, 8'd255));
      send_word(make_word(OP_UP, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_DOWN, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0));
      send_word(make_word(OP_UP, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0));
      send_word(make_word(OP_SET, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0));
      send_word(make_word(OP_DOWN, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_SET, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_DOWN, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_DOWN, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0));
      send_word(make_word(3'd5, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255));
      send_word(make_word(3'd6, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(3'd7, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255));
      send_word(make_word(OP_TICK, 8'd255, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_TICK, 8'd0, 8'd255, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_TICK, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255));
      send_word(make_word(OP_TICK, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0));
      send_word(make_word(OP_LOAD, 8'd1, 8'd1, 1'b0, 1'b0, 8'd40));

      apply_setting(TARGET_RESET, INC_MAX_RESET, INC_DEF_RESET, SPD_MIN_RESET);
      random_phase(250);
      apply_setting(8'd0, 8'd255, 8'd0, 8'd0);
      random_phase(250);
      apply_setting(8'd255, 8'd0, 8'd255, 8'd255);
      random_phase(250);
      repeat (3) begin
         apply_setting(8'($urandom_range(60, 200)), 8'($urandom_range(3, 40)),
                       8'($urandom_range(0, 5)), 8'($urandom_range(0, 30)));
         random_phase(280);
      end

      wait_drained();
      if (mismatch_count == 0 && readouts_due == 0)
         $display("heart_rate_incline_regulator test passed");
      else
         $display("heart_rate_incline_regulator test failed");
      $finish;
   end

endmodule
